// File: src/qll_pkg.sv
// Package: token kinds, lexer modes, result record and character classes.
`timescale 1ns / 1ps
package qll_pkg;

    localparam int unsigned MaxQueryLen = 65536;
    localparam int unsigned PosW = 16;
    localparam logic [PosW-1:0] PosMax = PosW'(MaxQueryLen - 1);

    localparam logic [4:0] K_END       = 5'd0;
    localparam logic [4:0] K_LBRACE    = 5'd1;
    localparam logic [4:0] K_RBRACE    = 5'd2;
    localparam logic [4:0] K_LPAREN    = 5'd3;
    localparam logic [4:0] K_RPAREN    = 5'd4;
    localparam logic [4:0] K_COLON     = 5'd5;
    localparam logic [4:0] K_LBRACKET  = 5'd6;
    localparam logic [4:0] K_RBRACKET  = 5'd7;
    localparam logic [4:0] K_BANG      = 5'd8;
    localparam logic [4:0] K_UNION     = 5'd9;
    localparam logic [4:0] K_DOT       = 5'd10;
    localparam logic [4:0] K_SPREAD    = 5'd11;
    localparam logic [4:0] K_EQUAL     = 5'd12;
    localparam logic [4:0] K_COMMENT   = 5'd13;
    localparam logic [4:0] K_PARAM     = 5'd14;
    localparam logic [4:0] K_DIRECTIVE = 5'd15;
    localparam logic [4:0] K_STRING    = 5'd16;
    localparam logic [4:0] K_BLOCK     = 5'd17;
    localparam logic [4:0] K_INT       = 5'd18;
    localparam logic [4:0] K_FLOAT     = 5'd19;
    localparam logic [4:0] K_NAME      = 5'd20;
    localparam logic [4:0] K_INVALID   = 5'd21;

    typedef enum logic [17:0] {
        M_IDLE      = 18'h00001,
        M_DOT1      = 18'h00002,
        M_DOT2      = 18'h00004,
        M_SIGIL_P   = 18'h00008,
        M_SIGIL_D   = 18'h00010,
        M_NAME      = 18'h00020,
        M_PARAM     = 18'h00040,
        M_DIRECTIVE = 18'h00080,
        M_COMMENT   = 18'h00100,
        M_STR_Q     = 18'h00200,
        M_STR_QQ    = 18'h00400,
        M_STR_BODY  = 18'h00800,
        M_NUM_SIGN  = 18'h01000,
        M_NUM_DIG   = 18'h02000,
        M_NUM_DOT   = 18'h04000,
        M_NUM_EXP   = 18'h08000,
        M_NUM_ESIGN = 18'h10000,
        M_DONE      = 18'h20000
    } t_mode;

    typedef struct packed {
        logic [4:0]      kind;
        logic [PosW-1:0] tok_offset;
        logic [PosW-1:0] token_len;
        logic            run_end;
    } t_tok;

    // Up to three tokens produced by one byte, slot 0 first.
    typedef struct packed {
        logic [2:0] vld;
        t_tok [2:0] tok;
    } t_group;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_first(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    function automatic logic [PosW-1:0] diff(input logic [PosW-1:0] a,
                                             input logic [PosW-1:0] b);
        return (a >= b) ? a - b : '0;
    endfunction

    function automatic logic [PosW-1:0] next_pos(input logic [PosW-1:0] p);
        return (p >= PosMax) ? PosMax : p + 1'b1;
    endfunction

endpackage

// File: src/query_language_lexer_unit.sv
// Top level of the streaming query lexer.
`timescale 1ns / 1ps
// Query lexer: one query byte per request in, tokens out.
// Input channel: i_valid / o_stall with i_char_byte and i_final_byte.
// Output channel: o_valid / i_stall with o_kind, o_tok_offset, o_token_len,
// o_run_end; o_run_end marks the last token caused by one byte.
// A byte yields zero to three tokens. The front lexer updates its state in
// the cycle the byte is accepted and pushes the group of tokens it closes
// into a two-entry queue; the back end sends one token per cycle while i_stall is low.
// The first token of a byte is sent from the queue entry written at acceptance.
// Throughput: one byte per cycle while bytes close at most one token and i_stall
// is low; a byte that yields several tokens holds the output port until all are sent.
// o_stall rises only when the queue is full, so a stalled receiver
// backs up the lexer after two pending groups.
// Reset (synchronous, active low) returns the lexer to idle at offset 0 and
// empties the queue. After the last byte the lexer returns to that state.
module query_language_lexer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_kind,
    output logic [15:0] o_tok_offset,
    output logic [15:0] o_token_len,
    output logic        o_run_end
);

    qll_pkg::t_group grp;
    qll_pkg::t_tok   tok;
    logic            full, take;

    assign o_stall = full;
    assign take    = i_valid && !full;

    qll_front u_front (
        .i_clk, .i_rst_n, .i_take(take), .i_char_byte, .i_final_byte, .o_group(grp)
    );

    // Empty groups are not queued.
    qll_back u_back (
        .i_clk, .i_rst_n, .i_push(take && grp.vld[0]), .i_group(grp),
        .o_full(full), .o_valid, .o_tok(tok), .i_stall
    );

    assign o_kind       = tok.kind;
    assign o_tok_offset = tok.tok_offset;
    assign o_token_len  = tok.token_len;
    assign o_run_end    = tok.run_end;

endmodule

// File: src/qll_front.sv
// Front end: lexer state machine, turns each byte into a group of tokens.
`timescale 1ns / 1ps
module qll_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_char_byte,
    input  logic              i_final_byte,
    output qll_pkg::t_group   o_group
);

    qll_pkg::t_mode r_mode, n_mode;
    logic [15:0] r_pos, r_tstart, n_tstart;
    logic [1:0]  r_nflags, n_nflags;
    logic [2:0]  r_sflags, n_sflags;
    logic [1:0]  r_qrun, n_qrun;
    qll_pkg::t_group g;
    logic [15:0] pos, npos;
    logic [7:0]  c;
    logic        relex;

    function automatic qll_pkg::t_tok mk(input logic [4:0] k, input logic [15:0] s,
                                         input logic [15:0] l);
        qll_pkg::t_tok t;
        t.kind = k; t.tok_offset = s; t.token_len = l; t.run_end = 1'b0;
        return t;
    endfunction

    always_comb begin
        logic [2:0] cnt;
        logic [4:0] pk;
        logic [15:0] s, ln;
        logic [1:0] q;
        cnt = '0;
        pk = qll_pkg::K_END;
        s = '0;
        ln = '0;
        q = '0;
        g = '0;
        c = i_char_byte;
        pos = r_pos;
        npos = qll_pkg::next_pos(r_pos);
        n_mode = r_mode;
        n_tstart = r_tstart;
        n_nflags = r_nflags;
        n_sflags = r_sflags;
        n_qrun = r_qrun;
        relex = 1'b0;
        // phase one: continue open token
        case (r_mode)
            qll_pkg::M_IDLE: relex = 1'b1;
            qll_pkg::M_DOT1: begin
                if (c == 8'h2e) n_mode = qll_pkg::M_DOT2;
                else begin
                    g.tok[0] = mk(qll_pkg::K_DOT, r_tstart, 16'd1); cnt = 3'd1; relex = 1'b1;
                end
            end
            qll_pkg::M_DOT2: begin
                if (c == 8'h2e) begin
                    g.tok[0] = mk(qll_pkg::K_SPREAD, r_tstart, 16'd3); cnt = 3'd1;
                    n_mode = qll_pkg::M_IDLE; n_tstart = pos;
                end else begin
                    g.tok[0] = mk(qll_pkg::K_INVALID, r_tstart, 16'd2); cnt = 3'd1;
                    relex = 1'b1;
                end
            end
            qll_pkg::M_SIGIL_P, qll_pkg::M_SIGIL_D: begin
                if (qll_pkg::is_first(c))
                    n_mode = (r_mode == qll_pkg::M_SIGIL_P) ? qll_pkg::M_PARAM
                                                           : qll_pkg::M_DIRECTIVE;
                else begin
                    g.tok[0] = mk(qll_pkg::K_INVALID, pos, 16'd1); cnt = 3'd1;
                    n_mode = qll_pkg::M_IDLE; n_tstart = pos;
                end
            end
            qll_pkg::M_NAME, qll_pkg::M_PARAM, qll_pkg::M_DIRECTIVE: begin
                if (!(qll_pkg::is_first(c) || qll_pkg::is_digit(c))) begin
                    pk = (r_mode == qll_pkg::M_NAME) ? qll_pkg::K_NAME :
                         (r_mode == qll_pkg::M_PARAM) ? qll_pkg::K_PARAM :
                         qll_pkg::K_DIRECTIVE;
                    g.tok[0] = mk(pk, r_tstart, qll_pkg::diff(pos, r_tstart));
                    cnt = 3'd1; relex = 1'b1;
                end
            end
            qll_pkg::M_COMMENT: begin
                if (c == 8'h0a || c == 8'h0d) begin
                    g.tok[0] = mk(qll_pkg::K_COMMENT, r_tstart,
                                  qll_pkg::diff(pos, r_tstart));
                    cnt = 3'd1; n_mode = qll_pkg::M_IDLE; n_tstart = pos;
                    n_nflags = '0; n_sflags = '0; n_qrun = '0;
                end
            end
            qll_pkg::M_STR_QQ: begin
                if (c == 8'h22) begin
                    n_sflags = 3'd1; n_qrun = '0; n_tstart = npos;
                    n_mode = qll_pkg::M_STR_BODY;
                end else begin
                    g.tok[0] = mk(qll_pkg::K_STRING, r_tstart, 16'd0); cnt = 3'd1;
                    relex = 1'b1;
                end
            end
            qll_pkg::M_STR_Q, qll_pkg::M_STR_BODY: begin
                if (r_mode == qll_pkg::M_STR_Q && c == 8'h22)
                    n_mode = qll_pkg::M_STR_QQ;
                else begin
                    n_mode = qll_pkg::M_STR_BODY;
                    if (r_sflags[1]) begin
                        n_sflags[1] = 1'b0; n_qrun = '0;
                    end else if (c == 8'h5c) begin
                        n_sflags[1] = 1'b1; n_qrun = '0;
                    end else if (c != 8'h22) begin
                        n_qrun = '0;
                    end else if (!r_sflags[0]) begin
                        g.tok[0] = mk(qll_pkg::K_STRING, r_tstart,
                                      qll_pkg::diff(pos, r_tstart));
                        cnt = 3'd1; n_mode = qll_pkg::M_IDLE; n_tstart = pos;
                        n_nflags = '0; n_sflags = '0; n_qrun = '0;
                    end else begin
                        q = (r_qrun == 2'd3) ? 2'd3 : r_qrun + 2'd1;
                        n_qrun = q;
                        if (r_qrun >= 2'd2) begin
                            g.tok[0] = mk(qll_pkg::K_BLOCK, r_tstart,
                                qll_pkg::diff(qll_pkg::diff(pos, r_tstart), 16'd2));
                            cnt = 3'd1; n_mode = qll_pkg::M_IDLE; n_tstart = pos;
                            n_nflags = '0; n_sflags = '0; n_qrun = '0;
                        end
                    end
                end
            end
            qll_pkg::M_NUM_SIGN, qll_pkg::M_NUM_DOT, qll_pkg::M_NUM_ESIGN,
            qll_pkg::M_NUM_EXP: begin
                if (qll_pkg::is_digit(c)) n_mode = qll_pkg::M_NUM_DIG;
                else if (r_mode == qll_pkg::M_NUM_EXP && (c == 8'h2b || c == 8'h2d))
                    n_mode = qll_pkg::M_NUM_ESIGN;
                else begin
                    g.tok[0] = mk(qll_pkg::K_INVALID, r_tstart,
                                  qll_pkg::diff(pos, r_tstart));
                    cnt = 3'd1; relex = 1'b1;
                end
            end
            qll_pkg::M_NUM_DIG: begin
                if (qll_pkg::is_digit(c)) n_mode = r_mode;
                else if (c == 8'h2e && r_nflags == 2'd0) begin
                    n_nflags[0] = 1'b1; n_mode = qll_pkg::M_NUM_DOT;
                end else if ((c == 8'h65 || c == 8'h45) && !r_nflags[1]) begin
                    n_nflags[1] = 1'b1; n_mode = qll_pkg::M_NUM_EXP;
                end else begin
                    g.tok[0] = mk((r_nflags != 2'd0) ? qll_pkg::K_FLOAT : qll_pkg::K_INT,
                                  r_tstart, qll_pkg::diff(pos, r_tstart));
                    cnt = 3'd1; relex = 1'b1;
                end
            end
            qll_pkg::M_DONE: n_mode = r_mode;
            default: relex = 1'b1;
        endcase
        // phase two: lex byte from idle
        if (relex) begin
            n_mode = qll_pkg::M_IDLE; n_tstart = pos;
            n_nflags = '0; n_sflags = '0; n_qrun = '0;
            pk = qll_pkg::K_INVALID;
            if (c == 8'h20 || (c >= 8'd9 && c <= 8'd13) || c == 8'h2c) pk = qll_pkg::K_END;
            else begin
                case (c)
                    8'h00: begin
                        g.tok[cnt[1:0]] = mk(qll_pkg::K_END, pos, 16'd0);
                        cnt = cnt + 3'd1;
                        n_mode = qll_pkg::M_DONE;
                    end
                    8'h7b: pk = qll_pkg::K_LBRACE;
                    8'h7d: pk = qll_pkg::K_RBRACE;
                    8'h28: pk = qll_pkg::K_LPAREN;
                    8'h29: pk = qll_pkg::K_RPAREN;
                    8'h3a: pk = qll_pkg::K_COLON;
                    8'h5b: pk = qll_pkg::K_LBRACKET;
                    8'h5d: pk = qll_pkg::K_RBRACKET;
                    8'h21: pk = qll_pkg::K_BANG;
                    8'h7c: pk = qll_pkg::K_UNION;
                    8'h3d: pk = qll_pkg::K_EQUAL;
                    8'h2e: n_mode = qll_pkg::M_DOT1;
                    8'h23: n_mode = qll_pkg::M_COMMENT;
                    8'h24: n_mode = qll_pkg::M_SIGIL_P;
                    8'h40: n_mode = qll_pkg::M_SIGIL_D;
                    8'h22: begin n_mode = qll_pkg::M_STR_Q; n_tstart = npos; end
                    default: begin
                        if (qll_pkg::is_digit(c)) n_mode = qll_pkg::M_NUM_DIG;
                        else if (c == 8'h2d || c == 8'h2b) n_mode = qll_pkg::M_NUM_SIGN;
                        else if (qll_pkg::is_first(c)) n_mode = qll_pkg::M_NAME;
                        else begin
                            g.tok[cnt[1:0]] = mk(qll_pkg::K_INVALID, pos, 16'd1);
                            cnt = cnt + 3'd1;
                        end
                    end
                endcase
                if (c != 8'h00 && pk != qll_pkg::K_INVALID) begin
                    g.tok[cnt[1:0]] = mk(pk, pos, 16'd1); cnt = cnt + 3'd1;
                end
            end
        end
        // phase three: last byte flushes and ends
        if (i_final_byte) begin
            if (n_mode != qll_pkg::M_DONE) begin
                ln = qll_pkg::diff(npos, n_tstart);
                pk = qll_pkg::K_END;
                s = n_tstart;
                case (n_mode)
                    qll_pkg::M_DOT1: begin pk = qll_pkg::K_DOT; ln = 16'd1; end
                    qll_pkg::M_DOT2: begin pk = qll_pkg::K_INVALID; ln = 16'd2; end
                    qll_pkg::M_SIGIL_P, qll_pkg::M_PARAM: pk = qll_pkg::K_PARAM;
                    qll_pkg::M_SIGIL_D, qll_pkg::M_DIRECTIVE: pk = qll_pkg::K_DIRECTIVE;
                    qll_pkg::M_NAME: pk = qll_pkg::K_NAME;
                    qll_pkg::M_COMMENT: pk = qll_pkg::K_COMMENT;
                    qll_pkg::M_STR_QQ: begin pk = qll_pkg::K_STRING; ln = 16'd0; end
                    qll_pkg::M_STR_Q, qll_pkg::M_STR_BODY: begin
                        pk = qll_pkg::K_INVALID;
                        s = qll_pkg::diff(n_tstart, n_sflags[0] ? 16'd3 : 16'd1);
                        ln = qll_pkg::diff(npos, s);
                    end
                    qll_pkg::M_NUM_DIG:
                        pk = (n_nflags != 2'd0) ? qll_pkg::K_FLOAT : qll_pkg::K_INT;
                    qll_pkg::M_NUM_SIGN, qll_pkg::M_NUM_DOT, qll_pkg::M_NUM_EXP,
                    qll_pkg::M_NUM_ESIGN: pk = qll_pkg::K_INVALID;
                    default: pk = qll_pkg::K_END;
                endcase
                if (pk != qll_pkg::K_END && cnt < 3'd3) begin
                    g.tok[cnt[1:0]] = mk(pk, s, ln); cnt = cnt + 3'd1;
                end
                if (cnt < 3'd3) begin
                    g.tok[cnt[1:0]] = mk(qll_pkg::K_END, npos, 16'd0); cnt = cnt + 3'd1;
                end
            end
            n_mode = qll_pkg::M_IDLE; n_tstart = '0;
            n_nflags = '0; n_sflags = '0; n_qrun = '0;
        end
        g.vld = (cnt == 3'd0) ? 3'b000 : (cnt == 3'd1) ? 3'b001 :
                (cnt == 3'd2) ? 3'b011 : 3'b111;
        if (cnt != 3'd0) g.tok[cnt[1:0] - 2'd1].run_end = 1'b1;
    end

    assign o_group = g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= qll_pkg::M_IDLE;
            r_pos    <= '0;
            r_tstart <= '0;
            r_nflags <= '0;
            r_sflags <= '0;
            r_qrun   <= '0;
        end else if (i_take) begin
            r_mode   <= n_mode;
            r_pos    <= i_final_byte ? '0 : npos;
            r_tstart <= n_tstart;
            r_nflags <= n_nflags;
            r_sflags <= n_sflags;
            r_qrun   <= n_qrun;
        end
    end

endmodule

// File: src/qll_back.sv
// Back end: token group queue and serializer onto the output channel.
`timescale 1ns / 1ps
module qll_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  qll_pkg::t_group i_group,
    output logic            o_full,
    output logic            o_valid,
    output qll_pkg::t_tok   o_tok,
    input  logic            i_stall
);

    // Two-entry group queue.
    qll_pkg::t_group r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] r_slot;
    logic       pop, last;
    qll_pkg::t_group head;

    assign head    = r_q[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_tok   = head.tok[r_slot];
    assign last    = (r_slot == 2'd2) || !head.vld[r_slot + 2'd1];
    assign pop     = o_valid && !i_stall && last;

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_group;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0; r_slot <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
            if (o_valid && !i_stall) r_slot <= last ? 2'd0 : r_slot + 2'd1;
        end
    end

endmodule

// File: src/qll_checker.sv
// Port-level checker for the query lexer, bound to the top level.
`timescale 1ns / 1ps
module qll_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [4:0]  o_kind,
    input logic [15:0] o_tok_offset,
    input logic [15:0] o_token_len,
    input logic        o_run_end
);

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_kind <= qll_pkg::K_INVALID) else $error("kind out of range");

    a_end_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == qll_pkg::K_END) |-> (o_token_len == 16'd0 && o_run_end))
        else $error("end token malformed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_kind) && $stable(o_tok_offset)))
        else $error("stalled token changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall) else $error("not empty after reset");

endmodule

bind query_language_lexer_unit qll_checker u_qll_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for the streaming query lexer.
`timescale 1ns / 1ps
module testbench;

    // Expected token record held by the scoreboard.
    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] tok_offset;
        logic [15:0] token_len;
        logic        run_end;
    } t_exp_tok;

    // Lexer modes local to the predictor.
    typedef enum int {
        LM_IDLE, LM_DOT1, LM_DOT2, LM_SIGP, LM_SIGD, LM_NAME, LM_PARAM, LM_DIR,
        LM_COMMENT, LM_STRQ, LM_STRQQ, LM_STRBODY, LM_NSIGN, LM_NDIG, LM_NDOT,
        LM_NEXP, LM_NESIGN, LM_DONE
    } t_lmode;

    // Scoreboard: predicts the tokens of each accepted request and checks
    // the tokens coming out in order.
    class token_board;
        t_exp_tok   pending[$];
        t_exp_tok   step_toks[$];
        t_lmode     mode;
        logic [15:0] pos, tstart;
        logic [1:0] nflags;
        logic [2:0] sflags;
        logic [1:0] qrun;
        int         errors;
        int         tokens_seen;

        function void clear();
            mode = LM_IDLE; pos = 0; tstart = 0; nflags = 0; sflags = 0; qrun = 0;
        endfunction

        function logic [15:0] nxt(logic [15:0] p);
            return (p == 16'hFFFF) ? p : p + 16'd1;
        endfunction

        function logic [15:0] sub0(logic [15:0] a, logic [15:0] b);
            return (a >= b) ? a - b : 16'd0;
        endfunction

        function bit dig(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit first(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        endfunction

        function void put(logic [4:0] k, logic [15:0] s, logic [15:0] l);
            t_exp_tok t;
            if (step_toks.size() >= 3) return;
            t.kind = k; t.tok_offset = s; t.token_len = l; t.run_end = 0;
            step_toks.push_back(t);
        endfunction

        // Byte seen between tokens.
        function void start_tok(logic [7:0] c, logic [15:0] p);
            mode = LM_IDLE; tstart = p; nflags = 0; sflags = 0; qrun = 0;
            if (c == " " || (c >= 9 && c <= 13) || c == ",") return;
            case (c)
                8'd0: begin put(qll_pkg::K_END, p, 0); mode = LM_DONE; end
                "{": put(qll_pkg::K_LBRACE, p, 1);
                "}": put(qll_pkg::K_RBRACE, p, 1);
                "(": put(qll_pkg::K_LPAREN, p, 1);
                ")": put(qll_pkg::K_RPAREN, p, 1);
                ":": put(qll_pkg::K_COLON, p, 1);
                "[": put(qll_pkg::K_LBRACKET, p, 1);
                "]": put(qll_pkg::K_RBRACKET, p, 1);
                "!": put(qll_pkg::K_BANG, p, 1);
                "|": put(qll_pkg::K_UNION, p, 1);
                "=": put(qll_pkg::K_EQUAL, p, 1);
                ".": mode = LM_DOT1;
                "#": mode = LM_COMMENT;
                "$": mode = LM_SIGP;
                "@": mode = LM_SIGD;
                "\"": begin mode = LM_STRQ; tstart = nxt(p); end
                default: begin
                    if (dig(c)) mode = LM_NDIG;
                    else if (c == "-" || c == "+") mode = LM_NSIGN;
                    else if (first(c)) mode = LM_NAME;
                    else put(qll_pkg::K_INVALID, p, 1);
                end
            endcase
        endfunction

        function void in_string(logic [7:0] c, logic [15:0] p);
            if (sflags[1]) begin sflags[1] = 0; qrun = 0; return; end
            if (c == "\\") begin sflags[1] = 1; qrun = 0; return; end
            if (c != "\"") begin qrun = 0; return; end
            if (!sflags[0]) begin
                put(qll_pkg::K_STRING, tstart, sub0(p, tstart));
                start_tok(" ", p);
                return;
            end
            qrun++;
            if (qrun >= 3) begin
                put(qll_pkg::K_BLOCK, tstart, sub0(sub0(p, tstart), 2));
                start_tok(" ", p);
            end
        endfunction

        function void lex(logic [7:0] c, logic [15:0] p);
            case (mode)
                LM_DOT1: if (c == ".") mode = LM_DOT2;
                    else begin put(qll_pkg::K_DOT, tstart, 1); start_tok(c, p); end
                LM_DOT2: if (c == ".") begin
                        put(qll_pkg::K_SPREAD, tstart, 3); start_tok(" ", p);
                    end else begin
                        put(qll_pkg::K_INVALID, tstart, 2); start_tok(c, p);
                    end
                LM_SIGP, LM_SIGD: if (first(c)) mode = (mode == LM_SIGP) ? LM_PARAM : LM_DIR;
                    else begin put(qll_pkg::K_INVALID, p, 1); start_tok(" ", p); end
                LM_NAME, LM_PARAM, LM_DIR: if (!(first(c) || dig(c))) begin
                    put(mode == LM_NAME ? qll_pkg::K_NAME :
                        (mode == LM_PARAM ? qll_pkg::K_PARAM : qll_pkg::K_DIRECTIVE),
                        tstart, sub0(p, tstart));
                    start_tok(c, p);
                end
                LM_COMMENT: if (c == "\n" || c == "\r") begin
                    put(qll_pkg::K_COMMENT, tstart, sub0(p, tstart));
                    start_tok(" ", p);
                end
                LM_STRQ: if (c == "\"") mode = LM_STRQQ;
                    else begin mode = LM_STRBODY; in_string(c, p); end
                LM_STRQQ: if (c == "\"") begin
                        sflags = 1; qrun = 0; tstart = nxt(p); mode = LM_STRBODY;
                    end else begin put(qll_pkg::K_STRING, tstart, 0); start_tok(c, p); end
                LM_STRBODY: in_string(c, p);
                LM_NSIGN, LM_NDOT, LM_NESIGN: if (dig(c)) mode = LM_NDIG;
                    else begin
                        put(qll_pkg::K_INVALID, tstart, sub0(p, tstart)); start_tok(c, p);
                    end
                LM_NEXP: if (dig(c)) mode = LM_NDIG;
                    else if (c == "+" || c == "-") mode = LM_NESIGN;
                    else begin
                        put(qll_pkg::K_INVALID, tstart, sub0(p, tstart)); start_tok(c, p);
                    end
                LM_NDIG: begin
                    if (dig(c)) ;
                    else if (c == "." && nflags == 0) begin nflags[0] = 1; mode = LM_NDOT; end
                    else if ((c == "e" || c == "E") && !nflags[1]) begin
                        nflags[1] = 1; mode = LM_NEXP;
                    end else begin
                        put(nflags != 0 ? qll_pkg::K_FLOAT : qll_pkg::K_INT,
                            tstart, sub0(p, tstart));
                        start_tok(c, p);
                    end
                end
                LM_DONE: ;
                default: start_tok(c, p);
            endcase
        endfunction

        // Close whatever token is open when the last byte arrives.
        function void close_open(logic [15:0] e);
            logic [15:0] len, s;
            len = sub0(e, tstart);
            case (mode)
                LM_DOT1: put(qll_pkg::K_DOT, tstart, 1);
                LM_DOT2: put(qll_pkg::K_INVALID, tstart, 2);
                LM_SIGP, LM_PARAM: put(qll_pkg::K_PARAM, tstart, len);
                LM_SIGD, LM_DIR: put(qll_pkg::K_DIRECTIVE, tstart, len);
                LM_NAME: put(qll_pkg::K_NAME, tstart, len);
                LM_COMMENT: put(qll_pkg::K_COMMENT, tstart, len);
                LM_STRQQ: put(qll_pkg::K_STRING, tstart, 0);
                LM_STRQ, LM_STRBODY: begin
                    s = sub0(tstart, sflags[0] ? 16'd3 : 16'd1);
                    put(qll_pkg::K_INVALID, s, sub0(e, s));
                end
                LM_NDIG: put(nflags != 0 ? qll_pkg::K_FLOAT : qll_pkg::K_INT, tstart, len);
                LM_NSIGN, LM_NDOT, LM_NEXP, LM_NESIGN: put(qll_pkg::K_INVALID, tstart, len);
                default: ;
            endcase
        endfunction

        // Accepted request: predict its tokens.
        function void note_byte(logic [7:0] c, logic fin);
            logic [15:0] p;
            t_exp_tok t;
            step_toks.delete();
            p = pos;
            lex(c, p);
            pos = nxt(p);
            if (fin) begin
                if (mode != LM_DONE) begin
                    close_open(pos);
                    put(qll_pkg::K_END, pos, 0);
                end
                clear();
            end
            foreach (step_toks[i]) begin
                t = step_toks[i];
                t.run_end = (i == step_toks.size() - 1);
                pending.push_back(t);
            end
        endfunction

        function void check_tok(t_exp_tok got);
            t_exp_tok want;
            tokens_seen++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected token %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [7:0]  i_char_byte = 0;
    logic        i_final_byte = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [4:0]  o_kind;
    logic [15:0] o_tok_offset;
    logic [15:0] o_token_len;
    logic        o_run_end;

    query_language_lexer_unit i_dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    token_board board = new();
    int  cycle_count = 0;
    int  bytes_sent = 0;
    bit  calm = 0;     // no idling on either side while set
    bit  done_tx = 0;

    // Output side: sample at the rising edge, stall at random.
    always @(posedge i_clk) begin
        t_exp_tok t;
        cycle_count++;
        if (i_rst_n && o_valid && !i_stall) begin
            t.kind = o_kind; t.tok_offset = o_tok_offset;
            t.token_len = o_token_len; t.run_end = o_run_end;
            board.check_tok(t);
        end
        if (cycle_count > 400000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_stall <= !calm && ($urandom_range(0, 99) < 10);

    // Send one byte: drive at the falling edge, hold until accepted.
    // Valid stays up after acceptance; the next call may idle at random first, stop_tx drops it.
    task automatic send_byte(logic [7:0] c, logic fin);
        while (!calm && $urandom_range(0, 99) < 10) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1; i_char_byte <= c; i_final_byte <= fin;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_byte(c, fin);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic stop_tx();
        i_valid <= 0;
    endtask

    task automatic send_text(string s, bit fin_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], fin_last && i == s.len() - 1);
    endtask

    // Random byte biased toward the lexer's interesting characters.
    function automatic logic [7:0] pick_byte();
        string alpha = "{}():[]!|=.#$@\"\\+-eE_aZ09 ,\n\r";
        int r = $urandom_range(0, 99);
        if (r < 55) return alpha[$urandom_range(0, alpha.len() - 1)];
        if (r < 80) return 8'($urandom_range("0", "9"));
        if (r < 90) return 8'($urandom_range("a", "z"));
        if (r < 92) return 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    // Well-formed token snippets, some with random numbers.
    function automatic string pick_snippet();
        string s;
        case ($urandom_range(0, 9))
            0: s = $sformatf("%0d", $urandom_range(0, 9999));
            1: s = $sformatf("-%0d.%0de+%0d", $urandom_range(0, 99), $urandom_range(0, 99),
                             $urandom_range(0, 9));
            2: s = "\"a\\\"b\"";
            3: s = "\"\"\"x\"\"y\"\"\"";
            4: s = "$var1";
            5: s = "@skip";
            6: s = "...";
            7: s = "#note\n";
            8: s = "query_Name";
            default: s = "{ }";
        endcase
        return {s, " "};
    endfunction

    task automatic wait_drained();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        board.clear();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: punctuators, spreads, sigils, strings, numbers, End cases.
        calm = 1;
        send_text("{}():[]!|=. .. ...", 0);
        send_text("$x @d $", 0);
        send_text("$1", 0);
        send_text("#c\r\"\"\"\"\" \"\"a\"\"\"q\\\"\"\"\"\"x", 1);
        send_text("+1.5E-3 12e 1.a ~", 0);
        send_byte(8'hFF, 0);
        send_byte(8'd0, 0);
        send_text("ab", 1);
        send_text("\"open", 1);
        stop_tx();
        calm = 0;
        // Hold off until every token has arrived.
        wait_drained();

        // Random: mostly token snippets, some raw noise, runs closed by a last byte.
        while (bytes_sent < 360) begin
            if ($urandom_range(0, 3) != 0) send_text(pick_snippet(), 0);
            else send_byte(pick_byte(), 0);
            if ($urandom_range(0, 19) == 0) send_byte(pick_byte(), 1);
            calm = (bytes_sent > 150 && bytes_sent < 220);
        end
        send_byte(pick_byte(), 1);
        stop_tx();
        calm = 0;
        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("sent %0d bytes, checked %0d tokens over punctuators, names, strings,",
                 bytes_sent, board.tokens_seen);
        $display("numbers, comments and end handling, %0d mismatches", board.errors);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// File: files.f
src/qll_pkg.sv
src/qll_front.sv
src/qll_back.sv
src/query_language_lexer_unit.sv
src/qll_checker.sv
tb/testbench.sv
